// File: hdl/lmsn_pkg.sv
package lmsn_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MAX_WINDOW_DEF = 64;

    localparam int PIXEL_W = 8;
    localparam int WIDTH_REG_W = 9;
    localparam int HEIGHT_REG_W = 9;
    localparam int WINDOW_REG_W = 7;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_WINDOW_SIZE  = 2'd2
    } t_cfg_reg;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_POS,
        S_WIN,
        S_PGET,
        S_SUM,
        S_DRAIN,
        S_MUL,
        S_DIV_MEAN,
        S_RND,
        S_OUT
    } t_state;

endpackage

// File: hdl/lmsn_in_if.sv
interface lmsn_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [lmsn_pkg::PIXEL_W-1:0]    pixel;

    modport source(output valid, output kind, output pixel, input ready);
    modport sink(input valid, input kind, input pixel, output ready);
endinterface

// File: hdl/lmsn_out_if.sv
interface lmsn_out_if;
    logic                            valid;
    logic                            ready;
    logic [lmsn_pkg::PIXEL_W-1:0]    result_pixel;
    logic                            last;

    modport source(output valid, output result_pixel, output last, input ready);
    modport sink(input valid, input result_pixel, input last, output ready);
endinterface

// File: hdl/local_mean_subtract_normalizer_top.sv
// Center-surround local mean subtraction on an 8-bit grey image.
// Input channel i_in carries items with a kind bit and a pixel. A load item
// (kind 0) stores the next pixel in raster order; loads past the end of the
// image are dropped. Once the image is complete, each read item (kind 1)
// produces one item on o_out: the pixel minus the mean of its surround
// window, rounded half-to-even and saturated, with last set on the final
// pixel, after which the block is ready for the next image.
// A read item runs on one shared restoring divider and one memory read port:
// the divider splits the pixel index into row and column, the window bounds
// and the centre pixel are set up, the window is summed one pixel per cycle
// (up to window_size squared pixels), a drain and a multiply step follow,
// then the mean division, rounding and output. The divider width DW is 21 at the defaults.
// The block takes no new item until a read item has finished; a finished
// item waits in the output register while the receiver stalls, and the
// next item is accepted meanwhile. Reset clears the counters and restores
// the register defaults (64 by 64, window 16); the pixel memory is not
// cleared and is read only where it was loaded.
module local_mean_subtract_normalizer_top #(
    parameter int MAX_WIDTH  = lmsn_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lmsn_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WINDOW = lmsn_pkg::MAX_WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lmsn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lmsn_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    lmsn_in_if.sink                            i_in,
    lmsn_out_if.source                         o_out
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW   = $clog2(DEPTH + 1);
    localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CW     = $clog2(MAXDIM + 1);
    localparam int WSW    = $clog2(MAX_WINDOW + 1);
    localparam int BW     = ((CW > WSW) ? CW : WSW) + 1;
    localparam int HMAX   = MAX_WINDOW / 2;
    localparam int AREAW  = $clog2((2 * HMAX) * (2 * HMAX) + 1);
    localparam int SUMW   = AREAW + lmsn_pkg::PIXEL_W;
    localparam int DW     = (SUMW > CNTW) ? SUMW : CNTW;
    localparam int DCW    = $clog2(DW + 1);
    localparam int PW     = lmsn_pkg::PIXEL_W;

    logic [lmsn_pkg::WIDTH_REG_W-1:0]  r_cfg_w;
    logic [lmsn_pkg::HEIGHT_REG_W-1:0] r_cfg_h;
    logic [lmsn_pkg::WINDOW_REG_W-1:0] r_cfg_ws;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= lmsn_pkg::WIDTH_REG_W'(64);
            r_cfg_h  <= lmsn_pkg::HEIGHT_REG_W'(64);
            r_cfg_ws <= lmsn_pkg::WINDOW_REG_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lmsn_pkg::REG_IMAGE_WIDTH:  r_cfg_w  <= i_cfg_data[lmsn_pkg::WIDTH_REG_W-1:0];
                lmsn_pkg::REG_IMAGE_HEIGHT: r_cfg_h  <= i_cfg_data[lmsn_pkg::HEIGHT_REG_W-1:0];
                lmsn_pkg::REG_WINDOW_SIZE:  r_cfg_ws <= i_cfg_data[lmsn_pkg::WINDOW_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective geometry after clamping.
    logic [CW-1:0]  w_eff;
    logic [CW-1:0]  h_eff;
    logic [WSW-1:0] w_half;
    int             v_w, v_h, v_ws;

    always_comb begin
        v_w  = int'(r_cfg_w);
        v_h  = int'(r_cfg_h);
        v_ws = int'(r_cfg_ws);
        if (v_w < 1) v_w = 1;
        if (v_w > MAX_WIDTH) v_w = MAX_WIDTH;
        if (v_h < 1) v_h = 1;
        if (v_h > MAX_HEIGHT) v_h = MAX_HEIGHT;
        if (v_ws > MAX_WINDOW) v_ws = MAX_WINDOW;
        w_eff  = CW'(v_w);
        h_eff  = CW'(v_h);
        w_half = WSW'(v_ws / 2);
    end

    logic [CNTW-1:0] r_total;

    always_ff @(posedge i_clk) begin
        r_total <= CNTW'(w_eff * h_eff);
    end

    // Pixel memory.
    logic [PW-1:0] mem [DEPTH];
    logic          w_we;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic [PW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wr_addr] <= i_in.pixel;
        end
        r_rd <= mem[w_rd_addr];
    end

    lmsn_pkg::t_state r_state, n_state;
    logic [CNTW-1:0]  r_load, n_load;
    logic [CNTW-1:0]  r_emit, n_emit;
    logic [DW:0]      r_rem, n_rem;
    logic [DW-1:0]    r_quo, n_quo;
    logic [DW-1:0]    r_div, n_div;
    logic [DCW-1:0]   r_dcnt, n_dcnt;
    logic [CW-1:0]    r_r0, n_r0, r_r1, n_r1, r_c0, n_c0, r_c1, n_c1;
    logic [CW-1:0]    r_y, n_y, r_x, n_x;
    logic [CNTW-1:0]  r_rowbase, n_rowbase;
    logic [PW-1:0]    r_p, n_p;
    logic [AREAW-1:0] r_area, n_area;
    logic [SUMW-1:0]  r_sum, n_sum;
    logic             r_pend, n_pend;
    logic [PW-1:0]    r_res, n_res;
    logic             r_out_valid, n_out_valid;
    logic [PW-1:0]    r_out_pix, n_out_pix;
    logic             r_out_last, n_out_last;

    logic [DW:0]      w_trial;
    logic [BW-1:0]    w_i, w_j, w_hb, w_hgt, w_wid;
    logic [SUMW-1:0]  w_prod;
    logic [DW+1:0]    w_twice_r;
    logic [DW:0]      w_q_rnd;

    assign i_in.ready        = (r_state == lmsn_pkg::S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.result_pixel = r_out_pix;
    assign o_out.last        = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_load      = r_load;
        n_emit      = r_emit;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div       = r_div;
        n_dcnt      = r_dcnt;
        n_r0        = r_r0;
        n_r1        = r_r1;
        n_c0        = r_c0;
        n_c1        = r_c1;
        n_y         = r_y;
        n_x         = r_x;
        n_rowbase   = r_rowbase;
        n_p         = r_p;
        n_area      = r_area;
        n_sum       = r_sum;
        n_pend      = 1'b0;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_pix   = r_out_pix;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_wr_addr   = r_load[AW-1:0];
        w_rd_addr   = r_emit[AW-1:0];

        w_trial   = {r_rem[DW-1:0], r_quo[DW-1]};
        w_i       = BW'(r_quo);
        w_j       = BW'(r_rem);
        w_hb      = BW'(w_half);
        w_hgt     = BW'(h_eff);
        w_wid     = BW'(w_eff);
        w_prod    = SUMW'(r_p * r_area);
        w_twice_r = {r_rem, 1'b0};
        w_q_rnd   = {1'b0, r_quo};

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_pend) begin
            n_sum = r_sum + SUMW'(r_rd);
        end

        unique case (r_state) inside
            lmsn_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.kind == lmsn_pkg::KIND_LOAD) begin
                        if (r_load < r_total) begin
                            w_we   = 1'b1;
                            n_load = r_load + 1'b1;
                        end
                    end else if (r_load >= r_total) begin
                        if (r_emit >= r_total) begin
                            n_load = '0;
                            n_emit = '0;
                        end else begin
                            n_rem   = '0;
                            n_quo   = DW'(r_emit);
                            n_div   = DW'(w_eff);
                            n_dcnt  = '0;
                            n_state = lmsn_pkg::S_DIV_POS;
                        end
                    end
                end
            end
            lmsn_pkg::S_DIV_POS, lmsn_pkg::S_DIV_MEAN: begin
                if (w_trial >= {1'b0, r_div}) begin
                    n_rem = w_trial - {1'b0, r_div};
                    n_quo = {r_quo[DW-2:0], 1'b1};
                end else begin
                    n_rem = w_trial;
                    n_quo = {r_quo[DW-2:0], 1'b0};
                end
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DCW'(DW - 1)) begin
                    n_state = (r_state == lmsn_pkg::S_DIV_POS) ? lmsn_pkg::S_WIN
                                                               : lmsn_pkg::S_RND;
                end
            end
            lmsn_pkg::S_WIN: begin
                n_r0 = (w_i >= w_hb) ? CW'(w_i - w_hb) : '0;
                n_r1 = (w_i + w_hb < w_hgt) ? CW'(w_i + w_hb) : CW'(w_hgt);
                n_c0 = (w_j >= w_hb) ? CW'(w_j - w_hb) : '0;
                n_c1 = (w_j + w_hb < w_wid) ? CW'(w_j + w_hb) : CW'(w_wid);
                n_state = lmsn_pkg::S_PGET;
            end
            lmsn_pkg::S_PGET: begin
                n_p = r_rd;
                if (w_half == '0) begin
                    n_res   = r_rd;
                    n_state = lmsn_pkg::S_OUT;
                end else begin
                    n_rowbase = CNTW'(r_r0 * w_eff);
                    n_area    = AREAW'((r_r1 - r_r0) * (r_c1 - r_c0));
                    n_y       = r_r0;
                    n_x       = r_c0;
                    n_sum     = '0;
                    n_state   = lmsn_pkg::S_SUM;
                end
            end
            lmsn_pkg::S_SUM: begin
                w_rd_addr = AW'(r_rowbase + CNTW'(r_x));
                n_pend    = 1'b1;
                if (r_x + 1'b1 == r_c1) begin
                    n_x       = r_c0;
                    n_y       = r_y + 1'b1;
                    n_rowbase = r_rowbase + CNTW'(w_eff);
                    if (r_y + 1'b1 == r_r1) begin
                        n_state = lmsn_pkg::S_DRAIN;
                    end
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            lmsn_pkg::S_DRAIN: begin
                n_state = lmsn_pkg::S_MUL;
            end
            lmsn_pkg::S_MUL: begin
                if (w_prod <= r_sum) begin
                    n_res   = '0;
                    n_state = lmsn_pkg::S_OUT;
                end else begin
                    n_rem   = '0;
                    n_quo   = DW'(w_prod - r_sum);
                    n_div   = DW'(r_area);
                    n_dcnt  = '0;
                    n_state = lmsn_pkg::S_DIV_MEAN;
                end
            end
            lmsn_pkg::S_RND: begin
                if (w_twice_r > (DW+2)'(r_area) ||
                    (w_twice_r == (DW+2)'(r_area) && r_quo[0])) begin
                    w_q_rnd = {1'b0, r_quo} + 1'b1;
                end
                n_res   = (w_q_rnd > (DW+1)'(255)) ? PW'(255) : PW'(w_q_rnd);
                n_state = lmsn_pkg::S_OUT;
            end
            lmsn_pkg::S_OUT: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_res;
                    n_out_last  = (r_emit + 1'b1 == r_total);
                    if (r_emit + 1'b1 == r_total) begin
                        n_emit = '0;
                        n_load = '0;
                    end else begin
                        n_emit = r_emit + 1'b1;
                    end
                    n_state = lmsn_pkg::S_IDLE;
                end
            end
            default: n_state = lmsn_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmsn_pkg::S_IDLE;
            r_load      <= '0;
            r_emit      <= '0;
            r_dcnt      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load      <= n_load;
            r_emit      <= n_emit;
            r_dcnt      <= n_dcnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_div     <= n_div;
        r_r0      <= n_r0;
        r_r1      <= n_r1;
        r_c0      <= n_c0;
        r_c1      <= n_c1;
        r_y       <= n_y;
        r_x       <= n_x;
        r_rowbase <= n_rowbase;
        r_p       <= n_p;
        r_area    <= n_area;
        r_sum     <= n_sum;
        r_res     <= n_res;
        r_out_pix <= n_out_pix;
        r_out_last <= n_out_last;
    end

    a_emit_le_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit <= r_load)
        else $error("emit count ran ahead of load count");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == lmsn_pkg::S_OUT))
        else $error("result appeared outside the output step");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lmsn_pkg::S_DIV_POS || r_state == lmsn_pkg::S_DIV_MEAN)
        |-> r_dcnt < DCW'(DW))
        else $error("divider ran past its width");

endmodule

// File: verif/local_mean_subtract_normalizer_top_test.sv
`timescale 1ns / 1ps

module local_mean_subtract_normalizer_top_test;

    typedef struct {
        logic [lmsn_pkg::PIXEL_W-1:0] value;
        logic                         last;
    } t_out_pixel;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [lmsn_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [lmsn_pkg::CFG_DATA_W-1:0] i_cfg_data;

    lmsn_in_if  in_ch();
    lmsn_out_if out_ch();

    local_mean_subtract_normalizer_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in(in_ch),
        .o_out(out_ch)
    );

    logic [7:0] image_mem [0:65535];
    int unsigned loaded_n;
    int unsigned emitted_n;
    logic [lmsn_pkg::WIDTH_REG_W-1:0] width_reg;
    logic [lmsn_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [lmsn_pkg::WINDOW_REG_W-1:0] window_reg;

    t_out_pixel pending_pixels[$];
    int mismatches;
    int quiet;
    int hold_req;
    int stall_left;
    int sent_n;
    longint cycles;

    always #6 i_clk = ~i_clk;

    function automatic int eff_width();
        return (width_reg == 0) ? 1 : (width_reg > lmsn_pkg::MAX_WIDTH_DEF)
            ? lmsn_pkg::MAX_WIDTH_DEF : width_reg;
    endfunction

    function automatic int eff_height();
        return (height_reg == 0) ? 1 : (height_reg > lmsn_pkg::MAX_HEIGHT_DEF)
            ? lmsn_pkg::MAX_HEIGHT_DEF : height_reg;
    endfunction

    function automatic int reach();
        int ws;
        ws = (window_reg > lmsn_pkg::MAX_WINDOW_DEF) ? lmsn_pkg::MAX_WINDOW_DEF : window_reg;
        return ws / 2;
    endfunction

    function automatic logic [7:0] centered_pixel(int idx, int w, int ht);
        int h, i, j, r0, r1, c0, c1;
        longint p, s, area, num, q, r;
        h = reach();
        i = idx / w;
        j = idx % w;
        r0 = (i >= h) ? i - h : 0;
        r1 = (i + h < ht) ? i + h : ht;
        c0 = (j >= h) ? j - h : 0;
        c1 = (j + h < w) ? j + h : w;
        p = image_mem[idx];
        if (r1 <= r0 || c1 <= c0) return p[7:0];
        area = (r1 - r0) * (c1 - c0);
        s = 0;
        for (int y = r0; y < r1; y++)
            for (int x = c0; x < c1; x++)
                s += image_mem[y * w + x];
        if (p * area <= s) return 8'd0;
        num = p * area - s;
        q = num / area;
        r = num % area;
        if (2 * r > area || (2 * r == area && q[0])) q++;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic void apply_pixel_item(logic kind, logic [7:0] pix);
        int w, ht, total;
        t_out_pixel res;
        w = eff_width();
        ht = eff_height();
        total = w * ht;
        if (kind == lmsn_pkg::KIND_LOAD) begin
            if (loaded_n < total) begin
                image_mem[loaded_n] = pix;
                loaded_n++;
            end
            return;
        end
        if (loaded_n < total) return;
        if (emitted_n >= total) begin
            loaded_n = 0;
            emitted_n = 0;
            return;
        end
        res.value = centered_pixel(emitted_n, w, ht);
        res.last = (emitted_n + 1 == total);
        pending_pixels.push_back(res);
        emitted_n++;
        if (emitted_n == total) begin
            loaded_n = 0;
            emitted_n = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 4000000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: pixel %0d last %0b", out_ch.result_pixel,
                        out_ch.last);
            end else begin
                t_out_pixel e;
                e = pending_pixels.pop_front();
                if (e.value !== out_ch.result_pixel || e.last !== out_ch.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected pixel %0d last %0b, got %0d last %0b",
                            e.value, e.last, out_ch.result_pixel, out_ch.last);
                end
            end
            stall_left = quiet ? 0 : $urandom_range(0, 5);
        end
        if (hold_req > 0 || stall_left > 0) begin
            out_ch.ready <= 1'b0;
            if (hold_req == 0) stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        forever begin
            wait (hold_req > 0);
            repeat (hold_req) @(posedge i_clk);
            hold_req = 0;
        end
    end

    task automatic send_item(logic kind, logic [7:0] pix);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.pixel <= pix;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        apply_pixel_item(kind, pix);
        sent_n++;
    endtask

    task automatic wait_idle();
        int h;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        h = reach();
        repeat (200 + 4 * h * h + 8 * h) @(posedge i_clk);
    endtask

    task automatic write_reg(lmsn_pkg::t_cfg_reg idx, int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[lmsn_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lmsn_pkg::REG_IMAGE_WIDTH: width_reg = value[lmsn_pkg::WIDTH_REG_W-1:0];
            lmsn_pkg::REG_IMAGE_HEIGHT: height_reg = value[lmsn_pkg::HEIGHT_REG_W-1:0];
            default: window_reg = value[lmsn_pkg::WINDOW_REG_W-1:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_shape(int w, int ht, int ws);
        wait_idle();
        write_reg(lmsn_pkg::REG_IMAGE_WIDTH, w);
        write_reg(lmsn_pkg::REG_IMAGE_HEIGHT, ht);
        write_reg(lmsn_pkg::REG_WINDOW_SIZE, ws);
    endtask

    task automatic load_random(int n);
        for (int k = 0; k < n; k++)
            send_item(lmsn_pkg::KIND_LOAD, 8'($urandom_range(0, 255)));
    endtask

    task automatic read_pixels(int n);
        for (int k = 0; k < n; k++)
            send_item(lmsn_pkg::KIND_READ, 8'($urandom_range(0, 255)));
    endtask

    task automatic finish_image();
        while (loaded_n != 0 || emitted_n != 0) begin
            if (loaded_n < eff_width() * eff_height())
                send_item(lmsn_pkg::KIND_LOAD, 8'($urandom_range(0, 255)));
            else
                send_item(lmsn_pkg::KIND_READ, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_extreme_pixels();
        logic [7:0] vals [12] = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd0,
                                 8'd255, 8'd85, 8'd170, 8'd255, 8'd0, 8'd127};
        set_shape(4, 3, 2);
        send_item(lmsn_pkg::KIND_READ, 8'hFF);
        foreach (vals[k]) send_item(lmsn_pkg::KIND_LOAD, vals[k]);
        send_item(lmsn_pkg::KIND_LOAD, 8'h55);
        read_pixels(12);
    endtask

    task automatic test_empty_window();
        set_shape(3, 2, 1);
        load_random(6);
        read_pixels(6);
        set_shape(3, 2, 0);
        load_random(6);
        read_pixels(6);
    endtask

    task automatic test_wide_row();
        set_shape(511, 0, 127);
        load_random(256);
        read_pixels(256);
    endtask

    task automatic test_tall_column();
        set_shape(0, 256, 64);
        load_random(256);
        read_pixels(256);
    endtask

    task automatic test_mid_image_change();
        set_shape(4, 4, 4);
        load_random(16);
        read_pixels(4);
        set_shape(2, 2, 4);
        read_pixels(1);
        set_shape(3, 3, 3);
        load_random(5);
        set_shape(4, 4, 5);
        load_random(11);
        read_pixels(16);
    endtask

    task automatic test_output_hold();
        set_shape(6, 6, 4);
        load_random(36);
        hold_req = 400;
        read_pixels(36);
        wait_idle();
    endtask

    task automatic test_random_images();
        int w, ht, ws, n;
        while (sent_n < 1500) begin
            w = $urandom_range(1, 12);
            ht = $urandom_range(1, 12);
            ws = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(0, 10);
            set_shape(w, ht, ws);
            quiet = ($urandom_range(0, 3) == 0);
            n = w * ht;
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(lmsn_pkg::KIND_READ, 8'($urandom_range(0, 255)));
                send_item(lmsn_pkg::KIND_LOAD, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) == 0) load_random($urandom_range(1, 3));
            if ($urandom_range(0, 9) == 0) begin
                read_pixels($urandom_range(0, n - 1));
                set_shape($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 10));
                finish_image();
            end else begin
                read_pixels(n);
                if ($urandom_range(0, 9) == 0) read_pixels(1);
            end
            quiet = 0;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = lmsn_pkg::REG_IMAGE_WIDTH;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = lmsn_pkg::KIND_LOAD;
        in_ch.pixel = '0;
        out_ch.ready = 1'b0;
        loaded_n = 0;
        emitted_n = 0;
        width_reg = 64;
        height_reg = 64;
        window_reg = 16;
        mismatches = 0;
        quiet = 0;
        hold_req = 0;
        stall_left = 0;
        sent_n = 0;
        cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_pixels();
        test_empty_window();
        test_wide_row();
        test_tall_column();
        test_mid_image_change();
        test_output_hold();
        test_random_images();

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (pending_pixels.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/lmsn_pkg.sv
hdl/lmsn_in_if.sv
hdl/lmsn_out_if.sv
hdl/local_mean_subtract_normalizer_top.sv
verif/local_mean_subtract_normalizer_top_test.sv
